FILE: rtl/deq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and codes for the double-ended queue unit.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEQ_DEPTH   = 16;
    localparam int WORD_W      = 32;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 2;
    localparam int OCC_W       = 5;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd0;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd1;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 2'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Qualified shift/update commands broadcast to every cell.
    typedef struct packed {
        logic push_front;
        logic pop_front;
        logic push_back;
        logic pop_back;
    } t_deq_ctrl;

endpackage

FILE: rtl/deq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_cell
// One queue slot: a word and an occupied flag, shifted toward either
// neighbor on front operations and filled or freed at the tail on back ones.
// ----------------------------------------------------------------------------
module deq_cell
    import deq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_deq_ctrl         i_ctrl,
    input  logic [WORD_W-1:0] i_push_value,
    input  logic              i_left_valid,
    input  logic [WORD_W-1:0] i_left_data,
    input  logic              i_right_valid,
    input  logic [WORD_W-1:0] i_right_data,
    output logic              o_valid,
    output logic [WORD_W-1:0] o_data,
    output logic              o_tail
);

    logic              r_valid;
    logic              n_valid;
    logic [WORD_W-1:0] r_data;
    logic [WORD_W-1:0] n_data;

    assign o_tail = r_valid & ~i_right_valid;

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        if (i_ctrl.push_front) begin
            n_valid = i_left_valid;
            n_data  = i_left_data;
        end else if (i_ctrl.pop_front) begin
            n_valid = i_right_valid;
            n_data  = i_right_data;
        end else if (i_ctrl.push_back) begin
            if (!r_valid && i_left_valid) begin
                n_valid = 1'b1;
                n_data  = i_push_value;
            end
        end else if (i_ctrl.pop_back) begin
            if (o_tail) begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: rtl/double_ended_queue_unit.sv
`timescale 1ns / 1ps
// The result beat is registered: it strobes in the cycle after the request is taken.
// Throughput: one request per cycle; busy stays low, every cell shifts
// or updates in the same cycle as the request.
// Reset (synchronous, active low) empties the queue and clears the strobe;
// the receiver cannot stall, so every result beat is taken as it appears.
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded deque of signed words built as a row of cells, front at cell 0.
// ----------------------------------------------------------------------------
module double_ended_queue_unit
    import deq_pkg::*;
#(
    parameter int DEPTH = DEQ_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [OP_W-1:0]            i_op,
    input  logic signed [WORD_W-1:0]   i_push_value,
    output logic                       o_result_valid,
    output logic signed [WORD_W-1:0]   o_pop_value,
    output logic                       o_pop_valid,
    output logic [STATUS_W-1:0]        o_status,
    output logic [OCC_W-1:0]           o_occupancy
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DEPTH-1:0]  w_valid;
    logic [DEPTH-1:0]  w_tail;
    logic [WORD_W-1:0] w_data [DEPTH];

    logic              w_full;
    logic              w_empty;
    logic              w_accept;
    t_deq_ctrl         w_ctrl;
    logic [WORD_W-1:0] w_back_value;

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;

    logic              r_result_valid;
    logic [WORD_W-1:0] r_pop_value;
    logic [WORD_W-1:0] n_pop_value;
    logic              r_pop_valid;
    logic              n_pop_valid;
    logic [STATUS_W-1:0] r_status;
    logic [STATUS_W-1:0] n_status;

    assign busy     = 1'b0;
    assign w_accept = start & ~busy;
    assign w_full   = w_valid[DEPTH-1];
    assign w_empty  = ~w_valid[0];

    always_comb begin
        w_ctrl = '0;
        if (w_accept) begin
            case (i_op)
                OP_PUSH_FRONT: w_ctrl.push_front = ~w_full;
                OP_POP_FRONT:  w_ctrl.pop_front  = ~w_empty;
                OP_PUSH_BACK:  w_ctrl.push_back  = ~w_full;
                OP_POP_BACK:   w_ctrl.pop_back   = ~w_empty;
                default:       w_ctrl = '0;
            endcase
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic              w_lv;
        logic [WORD_W-1:0] w_ld;
        logic              w_rv;
        logic [WORD_W-1:0] w_rd;

        if (g == 0) begin : g_first
            assign w_lv = 1'b1;
            assign w_ld = i_push_value;
        end else begin : g_mid_l
            assign w_lv = w_valid[g-1];
            assign w_ld = w_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_rv = 1'b0;
            assign w_rd = '0;
        end else begin : g_mid_r
            assign w_rv = w_valid[g+1];
            assign w_rd = w_data[g+1];
        end

        deq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_push_value  (i_push_value),
            .i_left_valid  (w_lv),
            .i_left_data   (w_ld),
            .i_right_valid (w_rv),
            .i_right_data  (w_rd),
            .o_valid       (w_valid[g]),
            .o_data        (w_data[g]),
            .o_tail        (w_tail[g])
        );
    end

    // Tail flag is one-hot, so an AND-OR picks the back word.
    always_comb begin
        w_back_value = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_back_value = w_back_value | (w_data[k] & {WORD_W{w_tail[k]}});
        end
    end

    always_comb begin
        n_count     = r_count;
        n_pop_value = '0;
        n_pop_valid = 1'b0;
        n_status    = ST_OK;
        case (i_op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count     = r_count - 1'b1;
                    n_pop_valid = 1'b1;
                    n_pop_value = (i_op == OP_POP_FRONT) ? w_data[0] : w_back_value;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count        <= '0;
            r_result_valid <= 1'b0;
        end else begin
            r_result_valid <= w_accept;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pop_value <= n_pop_value;
            r_pop_valid <= n_pop_valid;
            r_status    <= n_status;
        end
    end

    assign o_result_valid = r_result_valid;
    assign o_pop_value    = r_pop_value;
    assign o_pop_valid    = r_pop_valid;
    assign o_status       = r_status;
    assign o_occupancy    = OCC_W'(r_count);

endmodule
